@@ rtl/bscgc_pkg.sv @@
package bscgc_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_GEN_POLY   = 2'd0;
    localparam logic [1:0] CFG_GEN_DEGREE = 2'd1;
    localparam logic [1:0] CFG_CHECK_MODE = 2'd2;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned POLY_W     = 32;
    localparam int unsigned DEGREE_W   = 6;

    typedef struct packed {
        logic data_bit;
        logic last_bit;
    } t_in;

    typedef struct packed {
        logic out_bit;
        logic is_crc_bit;
        logic error_flag;
        logic last_out;
    } t_out;

    typedef struct packed {
        logic [POLY_W-1:0]   gen_poly;
        logic [DEGREE_W-1:0] gen_degree;
        logic                check_mode;
    } t_cfg;

    // Control part of one queued job.
    typedef struct packed {
        logic data_bit;
        logic error_flag;
        logic last_out;
        logic has_crc;
    } t_job_ctl;

    localparam int unsigned JOB_CTL_W = $bits(t_job_ctl);

endpackage

@@ rtl/bit_serial_crc_gen_check_unit.sv @@
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_data  (data_bit, last_bit)
// output    out        o_valid / i_stall    o_data  (out_bit, is_crc_bit, error_flag, last_out)
// config    in         i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// One bit is accepted per cycle while o_stall is low; division is done at the transfer.
// A result passes through the job queue and the back end's output register; a
// generate-mode last bit adds one more output per CRC bit, from the serializer in the back end.
// A two-entry job queue takes up to two more bits while CRC bits drain or the
// output is stalled; once it is full, o_stall holds the input.
// Reset is synchronous and active low; it restores the default configuration.
module bit_serial_crc_gen_check_unit import bscgc_pkg::*; #(
    parameter int unsigned MAX_DEGREE = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in                   i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out                  o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int unsigned CW    = $clog2(MAX_DEGREE + 1);
    localparam int unsigned JOB_W = JOB_CTL_W + MAX_DEGREE + CW;

    t_cfg                  r_cfg;
    t_cfg                  n_cfg;
    logic                  accept;
    t_job_ctl              f_ctl;
    logic [MAX_DEGREE-1:0] f_crc;
    logic [CW-1:0]         f_len;
    logic [JOB_W-1:0]      q_data;
    logic                  q_empty;
    logic                  q_full;
    logic                  pop;
    t_job_ctl              b_ctl;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GEN_POLY:   n_cfg.gen_poly   = i_cfg_wdata[POLY_W-1:0];
                CFG_GEN_DEGREE: n_cfg.gen_degree = i_cfg_wdata[DEGREE_W-1:0];
                CFG_CHECK_MODE: n_cfg.check_mode = i_cfg_wdata[0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gen_poly   <= POLY_W'(7);
            r_cfg.gen_degree <= DEGREE_W'(8);
            r_cfg.check_mode <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    bscgc_front #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_data   (i_data),
        .o_ctl    (f_ctl),
        .o_crc    (f_crc),
        .o_len    (f_len)
    );

    bscgc_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  ({f_ctl, f_crc, f_len}),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign b_ctl = t_job_ctl'(q_data[JOB_W-1 -: JOB_CTL_W]);

    bscgc_back #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (q_empty),
        .i_ctl       (b_ctl),
        .i_crc       (q_data[CW +: MAX_DEGREE]),
        .i_len       (q_data[CW-1:0]),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

endmodule

@@ rtl/bscgc_front.sv @@
module bscgc_front import bscgc_pkg::*; #(
    parameter int unsigned MAX_DEGREE = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_cfg                               i_cfg,
    input  logic                               i_accept,
    input  t_in                                i_data,
    output t_job_ctl                           o_ctl,
    output logic [MAX_DEGREE-1:0]              o_crc,
    output logic [$clog2(MAX_DEGREE+1)-1:0]    o_len
);

    localparam int unsigned CW = $clog2(MAX_DEGREE + 1);
    localparam int unsigned IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

    logic [MAX_DEGREE-1:0]        r_rem;
    logic [MAX_DEGREE-1:0]        n_rem;
    logic [CW-1:0]                eff_deg;
    logic [IW-1:0]                top_idx;
    logic [MAX_DEGREE-1:0]        mask;
    logic [MAX_DEGREE+POLY_W-1:0] poly_wide;
    logic [MAX_DEGREE-1:0]        poly;
    logic [MAX_DEGREE-1:0]        rem_m;
    logic [MAX_DEGREE-1:0]        step;
    logic                         top;
    logic                         fb;

    // Degree zero runs as degree one; degrees above MAX_DEGREE saturate at it.
    always_comb begin
        if (i_cfg.gen_degree == '0) begin
            eff_deg = CW'(1);
        end else if ({1'b0, i_cfg.gen_degree} > 7'(MAX_DEGREE)) begin
            eff_deg = CW'(MAX_DEGREE);
        end else begin
            eff_deg = CW'(i_cfg.gen_degree);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_DEGREE; i++) begin
            mask[i] = (i < int'(eff_deg));
        end
    end

    assign poly_wide = {{MAX_DEGREE{1'b0}}, i_cfg.gen_poly};
    assign poly      = poly_wide[MAX_DEGREE-1:0] & mask;
    assign rem_m     = r_rem & mask;
    assign top_idx   = IW'(eff_deg - CW'(1));
    assign top       = rem_m[top_idx];

    // Check mode divides the codeword directly; generate mode divides the
    // message shifted up by the degree.
    always_comb begin
        if (i_cfg.check_mode) begin
            step = {rem_m[MAX_DEGREE-2:0], i_data.data_bit} & mask;
            fb   = top;
        end else begin
            step = {rem_m[MAX_DEGREE-2:0], 1'b0} & mask;
            fb   = top ^ i_data.data_bit;
        end
        if (fb) begin
            step = step ^ poly;
        end
    end

    always_comb begin
        o_ctl.data_bit   = i_data.data_bit;
        o_ctl.error_flag = i_cfg.check_mode & i_data.last_bit & (step != '0);
        o_ctl.last_out   = i_cfg.check_mode & i_data.last_bit;
        o_ctl.has_crc    = ~i_cfg.check_mode & i_data.last_bit;
        o_crc            = step;
        o_len            = eff_deg;
    end

    always_comb begin
        n_rem = r_rem;
        if (i_accept) begin
            n_rem = i_data.last_bit ? '0 : step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

endmodule

@@ rtl/bscgc_queue.sv @@
module bscgc_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic             n_wr;
    logic             n_rd;
    logic [1:0]       n_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr ^ i_push;
        n_rd  = r_rd ^ i_pop;
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/bscgc_back.sv @@
module bscgc_back import bscgc_pkg::*; #(
    parameter int unsigned MAX_DEGREE = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_job_empty,
    input  t_job_ctl                           i_ctl,
    input  logic [MAX_DEGREE-1:0]              i_crc,
    input  logic [$clog2(MAX_DEGREE+1)-1:0]    i_len,
    output logic                               o_pop,
    output logic                               o_valid,
    output t_out                               o_data,
    input  logic                               i_stall
);

    localparam int unsigned CW = $clog2(MAX_DEGREE + 1);
    localparam int unsigned IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

    logic                  r_valid;
    logic                  n_valid;
    t_out                  r_data;
    t_out                  n_data;
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         n_cnt;
    logic [MAX_DEGREE-1:0] r_crc;
    logic [MAX_DEGREE-1:0] n_crc;
    logic                  load;
    logic [IW-1:0]         idx;

    assign load    = !r_valid || !i_stall;
    assign idx     = IW'(r_cnt - CW'(1));
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // CRC bits leave highest order first, counting the index down.
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        n_cnt   = r_cnt;
        n_crc   = r_crc;
        o_pop   = 1'b0;
        if (load) begin
            if (r_cnt != '0) begin
                n_valid           = 1'b1;
                n_data.out_bit    = r_crc[idx];
                n_data.is_crc_bit = 1'b1;
                n_data.error_flag = 1'b0;
                n_data.last_out   = (r_cnt == CW'(1));
                n_cnt             = r_cnt - CW'(1);
            end else if (!i_job_empty) begin
                o_pop             = 1'b1;
                n_valid           = 1'b1;
                n_data.out_bit    = i_ctl.data_bit;
                n_data.is_crc_bit = 1'b0;
                n_data.error_flag = i_ctl.error_flag;
                n_data.last_out   = i_ctl.last_out;
                if (i_ctl.has_crc) begin
                    n_cnt = i_len;
                    n_crc = i_crc;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_crc  <= n_crc;
    end

endmodule

@@ dv/crc_frame_checker.sv @@
`timescale 1ns / 100ps

// Watches the bit stream into and out of the CRC unit, runs its own division
// register, and compares every output transfer with the oldest predicted result.
module crc_frame_checker import bscgc_pkg::*; #(
    parameter int unsigned MAX_DEGREE = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in                   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out                  i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [POLY_W-1:0]   poly_q;
    logic [DEGREE_W-1:0] degree_q;
    logic                check_q;
    logic [63:0]         rem_q;
    t_out                out_bits_due[$];
    t_out                due;
    int                  errs;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // One division step per accepted bit; queues the results that bit produces.
    task automatic crc_divide_bit(input t_in item);
        int unsigned d;
        logic [63:0] mask;
        logic [63:0] poly;
        logic [63:0] rem;
        logic        msb;
        d = degree_q;
        if (d < 1) d = 1;
        if (d > MAX_DEGREE) d = MAX_DEGREE;
        mask = (64'd1 << d) - 64'd1;
        poly = {32'd0, poly_q} & mask;
        rem  = rem_q & mask;
        msb  = rem[d-1];
        if (check_q) begin
            rem = ((rem << 1) | 64'(item.data_bit)) & mask;
            if (msb) rem ^= poly;
            out_bits_due.push_back(t_out'({item.data_bit, 1'b0,
                                           item.last_bit && (rem != 64'd0),
                                           item.last_bit}));
            rem_q = item.last_bit ? 64'd0 : rem;
        end else begin
            // Augmented division: the bit enters at x^d.
            rem = (rem << 1) & mask;
            if (msb ^ item.data_bit) rem ^= poly;
            out_bits_due.push_back(t_out'({item.data_bit, 3'b000}));
            if (item.last_bit) begin
                for (int unsigned k = 0; k < d; k++) begin
                    out_bits_due.push_back(t_out'({rem[d-1-k], 1'b1, 1'b0,
                                                   1'(k + 1 == d)}));
                end
                rem = 64'd0;
            end
            rem_q = rem;
        end
    endtask

    always @(posedge i_clk) begin
        errs = 0;
        if (!i_rst_n) begin
            poly_q   = 32'd7;
            degree_q = 6'd8;
            check_q  = 1'b0;
            rem_q    = 64'd0;
            out_bits_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GEN_POLY:   poly_q   = i_cfg_wdata[POLY_W-1:0];
                    CFG_GEN_DEGREE: degree_q = i_cfg_wdata[DEGREE_W-1:0];
                    CFG_CHECK_MODE: check_q  = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) crc_divide_bit(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (out_bits_due.size() == 0) begin
                    $error("result transfer %b with nothing expected", i_out_data);
                    errs++;
                end else begin
                    due = out_bits_due.pop_front();
                    if (i_out_data.out_bit !== due.out_bit) begin
                        $error("out_bit: expected %0b, got %0b", due.out_bit,
                               i_out_data.out_bit);
                        errs++;
                    end
                    if (i_out_data.is_crc_bit !== due.is_crc_bit) begin
                        $error("is_crc_bit: expected %0b, got %0b", due.is_crc_bit,
                               i_out_data.is_crc_bit);
                        errs++;
                    end
                    if (i_out_data.error_flag !== due.error_flag) begin
                        $error("error_flag: expected %0b, got %0b", due.error_flag,
                               i_out_data.error_flag);
                        errs++;
                    end
                    if (i_out_data.last_out !== due.last_out) begin
                        $error("last_out: expected %0b, got %0b", due.last_out,
                               i_out_data.last_out);
                        errs++;
                    end
                end
            end
        end
        o_fail_count <= o_fail_count + errs;
        o_pending    <= out_bits_due.size();
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import bscgc_pkg::*;

    localparam int LIMIT_CYCLES = 1_200_000;
    localparam int RANDOM_BITS  = 480;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    t_in                   i_data      = '0;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = CFG_GEN_POLY;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_out                  o_data;
    int                    fail_count;
    int                    pending;

    // Copy of the written configuration, used only to build valid codewords.
    logic [POLY_W-1:0]     cur_poly   = 32'd7;
    logic [DEGREE_W-1:0]   cur_degree = 6'd8;
    logic                  cur_check  = 1'b0;

    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int bits_sent;
    int frames_sent;
    int cfg_writes;

    bit_serial_crc_gen_check_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    crc_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * 12);
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver backpressure in random bursts.
    initial begin
        @(posedge i_clk);
        forever begin
            if (stalls_on && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    function automatic int unsigned crc_width();
        int unsigned d;
        d = cur_degree;
        if (d < 1) d = 1;
        if (d > 32) d = 32;
        return d;
    endfunction

    // Remainder of msg * x^d, which makes msg followed by it a clean codeword.
    function automatic logic [63:0] augmented_crc(input logic [63:0] msg, input int len);
        int unsigned d;
        logic [63:0] mask;
        logic [63:0] rem;
        logic        msb;
        d    = crc_width();
        mask = (64'd1 << d) - 64'd1;
        rem  = 64'd0;
        for (int i = len - 1; i >= 0; i--) begin
            msb = rem[d-1];
            rem = (rem << 1) & mask;
            if (msb ^ msg[i]) rem ^= {32'd0, cur_poly} & mask;
        end
        return rem;
    endfunction

    // Each of these tasks starts and ends just after a rising edge.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_GEN_POLY:   cur_poly   = value[POLY_W-1:0];
            CFG_GEN_DEGREE: cur_degree = value[DEGREE_W-1:0];
            CFG_CHECK_MODE: cur_check  = value[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    task automatic write_random_reg(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] value;
        case (idx)
            CFG_GEN_POLY: begin
                case ($urandom_range(0, 9))
                    0:       value = 32'd0;
                    1:       value = 32'hFFFF_FFFF;
                    default: value = $urandom;
                endcase
            end
            CFG_GEN_DEGREE: begin
                // Mostly short registers; long ones make every frame end slow.
                case ($urandom_range(0, 11))
                    0:       value = 32'd0;
                    1:       value = 32'd32;
                    2:       value = $urandom_range(33, 63);
                    3:       value = $urandom_range(17, 31);
                    default: value = $urandom_range(1, 16);
                endcase
            end
            default: value = $urandom_range(0, 1);
        endcase
        set_reg(idx, value);
    endtask

    task automatic send_bit(input logic data_bit, input logic last_bit);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data.data_bit <= data_bit;
        i_data.last_bit <= last_bit;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bits_sent++;
    endtask

    // Stop sending and wait until every predicted result has been transferred.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Sends frame[len-1:0], highest bit first. A nonzero split drains after that
    // many bits and rewrites one register before the rest of the frame.
    task automatic send_frame(input logic [63:0] frame, input int len, input int split);
        for (int i = len - 1; i >= 0; i--) begin
            if (split != 0 && i == len - 1 - split) begin
                drain_results();
                write_random_reg(CFG_IDX_W'($urandom_range(0, 2)));
            end
            send_bit(frame[i], i == 0);
        end
        frames_sent++;
    endtask

    initial begin
        logic [63:0] msg;
        logic [63:0] frame;
        int          len;
        int          kind;
        int          split;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default configuration, one-bit frames of both values.
        send_frame(64'd1, 1, 0);
        send_frame(64'd0, 1, 0);
        // Degree zero acts as degree one; the write lands in the middle of a frame.
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        drain_results();
        set_reg(CFG_GEN_DEGREE, 32'd0);
        set_reg(CFG_GEN_POLY, 32'd1);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        // Degree above the maximum saturates; all coefficients set.
        drain_results();
        set_reg(CFG_GEN_DEGREE, 32'd63);
        set_reg(CFG_GEN_POLY, 32'hFFFF_FFFF);
        send_frame(64'b101, 3, 0);
        drain_results();
        set_reg(CFG_GEN_DEGREE, 32'd32);
        set_reg(CFG_GEN_POLY, 32'h04C1_1DB7);
        send_frame(64'hA5, 8, 0);
        // Check mode with coefficients above the degree that must be ignored.
        drain_results();
        set_reg(CFG_GEN_DEGREE, 32'd3);
        set_reg(CFG_GEN_POLY, 32'hFFFF_FFF3);
        set_reg(CFG_CHECK_MODE, 32'd1);
        send_frame((64'b10 << 3) | augmented_crc(64'b10, 2), 5, 0);
        send_frame(64'd1, 1, 0);
        // Mode switched to generate in the middle of a frame.
        send_bit(1'b1, 1'b0);
        drain_results();
        set_reg(CFG_CHECK_MODE, 32'd0);
        send_bit(1'b0, 1'b1);

        while (bits_sent < 25 + RANDOM_BITS) begin
            drain_results();
            if (bits_sent > RANDOM_BITS - 60) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            write_random_reg(CFG_GEN_POLY);
            write_random_reg(CFG_GEN_DEGREE);
            write_random_reg(CFG_CHECK_MODE);
            repeat ($urandom_range(2, 6)) begin
                kind  = $urandom_range(0, 9);
                msg   = 64'($urandom);
                len   = $urandom_range(1, 10);
                frame = msg & ((64'd1 << len) - 64'd1);
                if (cur_check && kind < 8) begin
                    frame = (frame << crc_width()) | augmented_crc(frame, len);
                    len   = len + crc_width();
                    // A single flipped bit stands for a noisy channel.
                    if (kind == 7) frame ^= 64'd1 << $urandom_range(0, len - 1);
                end
                split = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : 0;
                send_frame(frame, len, split);
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d input bits in %0d frames with %0d register writes,",
                 bits_sent, frames_sent, cfg_writes);
        $display("in generate and check mode, degrees zero through 63, clean and corrupted codewords.");
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bscgc_pkg.sv
rtl/bscgc_front.sv
rtl/bscgc_queue.sv
rtl/bscgc_back.sv
rtl/bit_serial_crc_gen_check_unit.sv
dv/crc_frame_checker.sv
dv/tb.sv
